### rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/gnssd_pkg.sv
// Shared types and constants for the binary GNSS frame deframer.
// No dependencies; imported by the parser, the result register and the top of the block.
package gnssd_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h62;
  localparam logic [16:0] CHECK_BYTES   = 17'd2;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4088;

  // Role of each byte within the stream.
  localparam logic [1:0] ROLE_DROP    = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_CHECK   = 2'd3;

  // Frame events raised on the byte that ends or rejects a frame.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_GOOD     = 2'd1;
  localparam logic [1:0] EV_BAD_SUM  = 2'd2;
  localparam logic [1:0] EV_TOO_LONG = 2'd3;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_CLASS,
    ST_ID,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_LEN_CHECK,
    ST_BODY
  } fsm_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_role;
    logic [1:0]  frame_event;
    logic [7:0]  class_id;
    logic [7:0]  message_id;
    logic [15:0] payload_len;
    logic [31:0] corrupt_count;
  } result_t;

endpackage

### rtl/core/gnssd_in_stage.sv
// Input register of the deframer: holds one received word until the parser takes it.
// Depends on nothing but its ports.
module gnssd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       out_free,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       fire
);

  // The held word moves on whenever the result register can take a new result.
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

endmodule

### rtl/core/gnssd_parser.sv
// Frame state machine, running Fletcher checksum and corrupt frame counter.
// Uses gnssd_pkg; forms one result per word from the current frame state.
module gnssd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           s1_byte,
  input  logic [15:0]          max_len,
  output gnssd_pkg::result_t   result
);
  import gnssd_pkg::*;

  fsm_t        state;
  fsm_t        state_next;
  logic [16:0] remaining;
  logic [16:0] remaining_next;
  logic [7:0]  sum_a;
  logic [7:0]  sum_a_next;
  logic [7:0]  sum_b;
  logic [7:0]  sum_b_next;
  logic [7:0]  frame_class;
  logic [7:0]  frame_class_next;
  logic [7:0]  frame_id;
  logic [7:0]  frame_id_next;
  logic [7:0]  length_low;
  logic [7:0]  length_low_next;
  logic [15:0] frame_length;
  logic [15:0] frame_length_next;
  logic [7:0]  first_check_byte;
  logic [7:0]  first_check_byte_next;
  logic [31:0] bad_frames;
  logic [31:0] bad_frames_next;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [16:0] rem_eff;
  logic        too_long;
  logic [1:0]  role;
  logic [1:0]  event_code;
  logic        done;

  assign sum_a_add = sum_a + s1_byte;
  assign sum_b_add = sum_b + sum_a_add;
  assign too_long  = frame_length > max_len;
  // On the first byte after the header the count is loaded from the length field.
  assign rem_eff   = (state == ST_LEN_CHECK) ? ({1'b0, frame_length} + CHECK_BYTES) : remaining;

  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT:      state_next = (s1_byte == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
      ST_SYNC2:     state_next = (s1_byte == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
      ST_CLASS:     state_next = ST_ID;
      ST_ID:        state_next = ST_LEN_LO;
      ST_LEN_LO:    state_next = ST_LEN_HI;
      ST_LEN_HI:    state_next = ST_LEN_CHECK;
      ST_LEN_CHECK: begin
        if (too_long || rem_eff < CHECK_BYTES) begin
          state_next = ST_HUNT;
        end else begin
          state_next = ST_BODY;
        end
      end
      ST_BODY:      state_next = (rem_eff < CHECK_BYTES) ? ST_HUNT : ST_BODY;
      default:      state_next = ST_HUNT;
    endcase
  end

  always_comb begin
    role                  = ROLE_DROP;
    event_code            = EV_NONE;
    done                  = 1'b0;
    remaining_next        = remaining;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    frame_class_next      = frame_class;
    frame_id_next         = frame_id;
    length_low_next       = length_low;
    frame_length_next     = frame_length;
    first_check_byte_next = first_check_byte;
    bad_frames_next       = bad_frames;
    case (state)
      ST_HUNT: begin
        if (s1_byte == SYNC_FIRST) begin
          role = ROLE_HEADER;
        end
      end
      ST_SYNC2: begin
        if (s1_byte == SYNC_SECOND) begin
          role = ROLE_HEADER;
        end else begin
          done = 1'b1;
        end
      end
      ST_CLASS: begin
        role             = ROLE_HEADER;
        frame_class_next = s1_byte;
        sum_a_next       = sum_a_add;
        sum_b_next       = sum_b_add;
      end
      ST_ID: begin
        role          = ROLE_HEADER;
        frame_id_next = s1_byte;
        sum_a_next    = sum_a_add;
        sum_b_next    = sum_b_add;
      end
      ST_LEN_LO: begin
        role            = ROLE_HEADER;
        length_low_next = s1_byte;
        sum_a_next      = sum_a_add;
        sum_b_next      = sum_b_add;
      end
      ST_LEN_HI: begin
        role              = ROLE_HEADER;
        frame_length_next = {s1_byte, length_low};
        sum_a_next        = sum_a_add;
        sum_b_next        = sum_b_add;
      end
      ST_LEN_CHECK, ST_BODY: begin
        if (state == ST_LEN_CHECK && too_long) begin
          event_code      = EV_TOO_LONG;
          bad_frames_next = bad_frames + 32'd1;
          done            = 1'b1;
        end else begin
          if (rem_eff > CHECK_BYTES) begin
            role       = ROLE_PAYLOAD;
            sum_a_next = sum_a_add;
            sum_b_next = sum_b_add;
          end else if (rem_eff == CHECK_BYTES) begin
            role                  = ROLE_CHECK;
            first_check_byte_next = s1_byte;
          end else begin
            role = ROLE_CHECK;
            if (first_check_byte == sum_a && s1_byte == sum_b) begin
              event_code = EV_GOOD;
            end else begin
              event_code      = EV_BAD_SUM;
              bad_frames_next = bad_frames + 32'd1;
            end
            done = 1'b1;
          end
          remaining_next = rem_eff - 17'd1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // The result shows the frame as it stands after this byte, before any clearing.
  always_comb begin
    result.out_byte      = s1_byte;
    result.byte_role     = role;
    result.frame_event   = event_code;
    result.class_id      = frame_class_next;
    result.message_id    = frame_id_next;
    result.payload_len   = frame_length_next;
    result.corrupt_count = bad_frames_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_HUNT;
      remaining        <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
      frame_class      <= '0;
      frame_id         <= '0;
      length_low       <= '0;
      frame_length     <= '0;
      first_check_byte <= '0;
      bad_frames       <= '0;
    end else if (fire) begin
      state      <= state_next;
      bad_frames <= bad_frames_next;
      if (done) begin
        remaining        <= '0;
        sum_a            <= '0;
        sum_b            <= '0;
        frame_class      <= '0;
        frame_id         <= '0;
        length_low       <= '0;
        frame_length     <= '0;
        first_check_byte <= '0;
      end else begin
        remaining        <= remaining_next;
        sum_a            <= sum_a_next;
        sum_b            <= sum_b_next;
        frame_class      <= frame_class_next;
        frame_id         <= frame_id_next;
        length_low       <= length_low_next;
        frame_length     <= frame_length_next;
        first_check_byte <= first_check_byte_next;
      end
    end
  end

endmodule

### rtl/core/gnssd_out_stage.sv
// Result register of the deframer with its valid flag.
// Uses gnssd_pkg for the result structure.
module gnssd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  gnssd_pkg::result_t  result,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_free,
  output gnssd_pkg::result_t  res_q
);
  import gnssd_pkg::*;

  // A new result may enter when the register is empty or its word leaves now.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= result;
    end
  end

endmodule

### rtl/core/gnss_binary_frame_deframer.sv
// Binary GNSS frame deframer: one received word in, one annotated word out.
// An accepted word is held in the input register, then its result is registered in the result register.
// Throughput: one word per cycle while out_stall is low; the parser updates checksum and counters in a single pass.
// Reset (rst, synchronous): empties both registers, returns to hunting, clears the corrupt
// count and loads the payload limit with 4088. No clearing pass is needed.
`include "assert_macros.svh"

module gnss_binary_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_role,
  output logic [1:0]  frame_event,
  output logic [7:0]  class_id,
  output logic [7:0]  message_id,
  output logic [15:0] payload_len,
  output logic [31:0] corrupt_count
);
  import gnssd_pkg::*;

  logic [15:0] max_payload_len;
  logic        out_free;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        fire;
  result_t     result;
  result_t     res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_len <= cfg_data;
    end
  end

  gnssd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .out_free (out_free),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .fire     (fire)
  );

  gnssd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .s1_byte (s1_byte),
    .max_len (max_payload_len),
    .result  (result)
  );

  gnssd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res_q     (res_q)
  );

  assign out_byte      = res_q.out_byte;
  assign byte_role     = res_q.byte_role;
  assign frame_event   = res_q.frame_event;
  assign class_id      = res_q.class_id;
  assign message_id    = res_q.message_id;
  assign payload_len   = res_q.payload_len;
  assign corrupt_count = res_q.corrupt_count;

  `ASSERT_IMPLIES(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall, "input stalled while a stage is free")
  `ASSERT_NEXT(a_accept_is_held, in_valid && !in_stall, s1_valid, "accepted word not held in the input register")
  `ASSERT_IMPLIES(a_good_on_check, out_valid && frame_event == EV_GOOD, byte_role == ROLE_CHECK, "good frame flagged off a checksum word")

endmodule

### dv/deframer_checker.sv
`timescale 1ns / 100ps
// Checker for the binary GNSS frame deframer: watches the config, input and result channels,
// predicts each result word from its own copy of the parser state and compares field by field.
// Depends on gnssd_pkg for the role and event codes and the result layout.
module deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  byte_role,
  input  logic [1:0]  frame_event,
  input  logic [7:0]  class_id,
  input  logic [7:0]  message_id,
  input  logic [15:0] payload_len,
  input  logic [31:0] corrupt_count,
  output int          words_due,
  output int          fail_count
);
  import gnssd_pkg::*;

  localparam logic [16:0] HEADER_LEN = 17'd6;

  // Parser state as the block should hold it.
  logic [16:0] frame_pos;
  logic [16:0] body_left;
  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [7:0]  frame_cls;
  logic [7:0]  frame_msg;
  logic [7:0]  len_lo;
  logic [15:0] frame_len;
  logic [7:0]  check_a;
  logic [31:0] corrupt_total;
  logic [15:0] pay_limit;

  result_t     due_results[$];
  int          fails;

  assign fail_count = fails;

  initial begin
    fails     = 0;
    words_due = 0;
  end

  function automatic void drop_frame();
    frame_pos = '0;
    body_left = '0;
    acc_a     = '0;
    acc_b     = '0;
    frame_cls = '0;
    frame_msg = '0;
    len_lo    = '0;
    frame_len = '0;
    check_a   = '0;
  endfunction

  function automatic void fold_sum(input logic [7:0] b);
    acc_a = acc_a + b;
    acc_b = acc_b + acc_a;
  endfunction

  function automatic result_t deframe_step(input logic [7:0] b);
    result_t    r;
    logic [1:0] role;
    logic [1:0] ev;
    bit         done;
    role = ROLE_DROP;
    ev   = EV_NONE;
    done = 1'b0;
    case (frame_pos)
      17'd0: begin
        if (b == SYNC_FIRST) begin
          role      = ROLE_HEADER;
          frame_pos = 17'd1;
        end
      end
      17'd1: begin
        // A wrong second sync byte is dropped, not taken as a fresh first sync.
        if (b == SYNC_SECOND) begin
          role      = ROLE_HEADER;
          frame_pos = 17'd2;
        end else begin
          done = 1'b1;
        end
      end
      17'd2: begin
        frame_cls = b;
        fold_sum(b);
        role      = ROLE_HEADER;
        frame_pos = 17'd3;
      end
      17'd3: begin
        frame_msg = b;
        fold_sum(b);
        role      = ROLE_HEADER;
        frame_pos = 17'd4;
      end
      17'd4: begin
        len_lo = b;
        fold_sum(b);
        role      = ROLE_HEADER;
        frame_pos = 17'd5;
      end
      17'd5: begin
        frame_len = {b, len_lo};
        fold_sum(b);
        role      = ROLE_HEADER;
        frame_pos = HEADER_LEN;
      end
      default: begin
        // The length is judged on the first word after the header, against the limit
        // in force at that moment.
        if (frame_pos == HEADER_LEN && frame_len > pay_limit) begin
          ev            = EV_TOO_LONG;
          corrupt_total = corrupt_total + 32'd1;
          done          = 1'b1;
        end else begin
          if (frame_pos == HEADER_LEN) body_left = {1'b0, frame_len} + CHECK_BYTES;
          if (body_left > CHECK_BYTES) begin
            role = ROLE_PAYLOAD;
            fold_sum(b);
          end else if (body_left == CHECK_BYTES) begin
            role    = ROLE_CHECK;
            check_a = b;
          end else begin
            role = ROLE_CHECK;
            if (check_a == acc_a && b == acc_b) begin
              ev = EV_GOOD;
            end else begin
              ev            = EV_BAD_SUM;
              corrupt_total = corrupt_total + 32'd1;
            end
            done = 1'b1;
          end
          body_left = body_left - 17'd1;
          frame_pos = frame_pos + 17'd1;
        end
      end
    endcase
    r.out_byte      = b;
    r.byte_role     = role;
    r.frame_event   = ev;
    r.class_id      = frame_cls;
    r.message_id    = frame_msg;
    r.payload_len   = frame_len;
    r.corrupt_count = corrupt_total;
    if (done) drop_frame();
    return r;
  endfunction

  function automatic bit field_ok(input string label, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    bit      ok;
    if (rst) begin
      drop_frame();
      corrupt_total = '0;
      pay_limit     = MAX_LEN_RESET;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) pay_limit = cfg_data;
      // Results leave before new words are taken in: the block never answers in the
      // cycle it accepts a word.
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word %0h with nothing expected", $time, out_byte);
          fails++;
        end else begin
          want = due_results.pop_front();
          ok = field_ok("out_byte", 32'(want.out_byte), 32'(out_byte))
             & field_ok("byte_role", 32'(want.byte_role), 32'(byte_role))
             & field_ok("frame_event", 32'(want.frame_event), 32'(frame_event))
             & field_ok("class_id", 32'(want.class_id), 32'(class_id))
             & field_ok("message_id", 32'(want.message_id), 32'(message_id))
             & field_ok("payload_len", 32'(want.payload_len), 32'(payload_len))
             & field_ok("corrupt_count", want.corrupt_count, corrupt_count);
          if (!ok) fails++;
        end
      end
      if (in_valid && !in_stall) due_results.push_back(deframe_step(in_byte));
    end
    words_due <= due_results.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte stream stimulus and the verdict.
// Depends on gnssd_pkg, gnss_binary_frame_deframer and deframer_checker.
module testbench;
  import gnssd_pkg::*;

  localparam int DMG_NONE  = 0;
  localparam int DMG_SUM_A = 1;
  localparam int DMG_SUM_B = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  byte_role;
  logic [1:0]  frame_event;
  logic [7:0]  class_id;
  logic [7:0]  message_id;
  logic [15:0] payload_len;
  logic [31:0] corrupt_count;
  int          words_due;
  int          fail_count;

  logic [7:0]  tx_bytes[$];
  logic [15:0] cur_limit = MAX_LEN_RESET;
  logic [9:0]  stall_tick = '0;

  gnss_binary_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_role    (byte_role),
    .frame_event  (frame_event),
    .class_id     (class_id),
    .message_id   (message_id),
    .payload_len  (payload_len),
    .corrupt_count(corrupt_count)
  );

  deframer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_role    (byte_role),
    .frame_event  (frame_event),
    .class_id     (class_id),
    .message_id   (message_id),
    .payload_len  (payload_len),
    .corrupt_count(corrupt_count),
    .words_due    (words_due),
    .fail_count   (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver cycles through free running, light random, periodic and heavy stalling.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (stall_tick[2:0] < 3'd3);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  initial begin
    #5_000_000;
    $display("[gnss_binary_frame_deframer] ERROR");
    $finish;
  end

  // Sync, header, payload and checksum, with the checksum optionally spoilt. With
  // header_only set, only the sync and header words are queued.
  task automatic queue_frame(input logic [15:0] plen, input int damage, input bit header_only);
    logic [7:0] body[$];
    logic [7:0] ca;
    logic [7:0] cb;
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(plen[7:0]);
    body.push_back(plen[15:8]);
    if (!header_only) repeat (plen) body.push_back(8'($urandom));
    ca = '0;
    cb = '0;
    foreach (body[i]) begin
      ca = ca + body[i];
      cb = cb + ca;
    end
    if (damage == DMG_SUM_A) ca = ca ^ 8'(1 << $urandom_range(0, 7));
    else if (damage == DMG_SUM_B) cb = cb ^ 8'(1 << $urandom_range(0, 7));
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(SYNC_SECOND);
    foreach (body[i]) tx_bytes.push_back(body[i]);
    if (!header_only) begin
      tx_bytes.push_back(ca);
      tx_bytes.push_back(cb);
    end
  endtask

  function automatic logic [15:0] pick_len();
    logic [15:0] plen;
    plen = ($urandom_range(0, 14) == 0) ? 16'($urandom_range(0, 40))
                                        : 16'($urandom_range(0, 12));
    if (plen > cur_limit) plen = cur_limit;
    return plen;
  endfunction

  // Mostly well-formed frames with random content; the rest is noise and broken frames.
  task automatic queue_random_traffic(input int budget);
    int          pick;
    logic [7:0]  b;
    logic [15:0] plen;
    while (tx_bytes.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 68 || (pick < 88 && pick >= 80 && cur_limit == 16'hFFFF)) begin
        queue_frame(pick_len(), DMG_NONE, 1'b0);
      end else if (pick < 80) begin
        queue_frame(pick_len(), $urandom_range(DMG_SUM_A, DMG_SUM_B), 1'b0);
      end else if (pick < 88) begin
        plen = $urandom_range(0, 1) ? cur_limit + 16'd1
                                    : 16'($urandom_range(cur_limit + 1, 16'hFFFF));
        queue_frame(plen, DMG_NONE, 1'b1);
        tx_bytes.push_back(8'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
      end else if (pick < 98) begin
        b = 8'($urandom);
        if (b == SYNC_SECOND) b = b + 8'd1;
        tx_bytes.push_back(SYNC_FIRST);
        tx_bytes.push_back(b);
      end else begin
        // A cut-off frame: the next frame's words are swallowed as its tail.
        queue_frame(pick_len(), DMG_NONE, 1'b0);
        repeat ($urandom_range(1, 3)) void'(tx_bytes.pop_back());
      end
    end
  endtask

  // Sends the queued words in bursts; valid stays high across a burst and only drops
  // for a real gap, so it is never lowered and raised in one step.
  task automatic send_stream(input bit steady);
    int burst;
    int gap;
    while (tx_bytes.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && tx_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_byte  <= tx_bytes.pop_front();
        do @(posedge clk); while (in_stall);
        burst--;
      end
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 || tx_bytes.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = value;
  endtask

  initial begin
    logic [15:0] limits[5];
    limits[0] = 16'd5;
    limits[1] = 16'd0;
    limits[2] = 16'hFFFF;
    limits[3] = 16'($urandom_range(6, 40));
    limits[4] = MAX_LEN_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hunting noise, a bad second sync, a repeated first sync, an empty frame, an
    // over-long length, and a header left open across the next limit change.
    tx_bytes = {8'h00, 8'hFF, SYNC_SECOND, SYNC_FIRST, 8'h00, SYNC_FIRST, SYNC_FIRST};
    queue_frame(16'd0, DMG_NONE, 1'b0);
    queue_frame(16'hFFFF, DMG_NONE, 1'b1);
    tx_bytes.push_back(8'h5A);
    queue_frame(16'd10, DMG_NONE, 1'b1);
    send_stream(1'b0);

    foreach (limits[i]) begin
      wait_drained();
      write_limit(limits[i]);
      queue_random_traffic(80);
      send_stream(i == 3);
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("[gnss_binary_frame_deframer] OK");
    end else begin
      $display("[gnss_binary_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule
